FILE: sv/pmd_pkg.sv
// shared types and constants for the dense prim spanning tree block
// no dependencies; imported by pmd_ctrl, pmd_datapath and prim_mst_dense
package pmd_pkg;

    localparam int VTX_W     = 5;
    localparam int IN_W_W    = 16;
    localparam int OUT_W_W   = 16;
    localparam int TOTAL_W   = 21;
    localparam int VCNT_W    = 6;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_wr;
        logic run_init;
        logic scan_issue;
        logic commit;
    } pmd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
        logic final_round;
    } pmd_status_t;

endpackage

FILE: sv/pmd_ctrl.sv
// sequencer for the dense prim spanning tree block: idle, scan, drain, emit
// depends on pmd_pkg for the command and status structs
module pmd_ctrl
    import pmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_action,
    output logic        s_tready,
    input  pmd_status_t status,
    output pmd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (s_action == ACT_START) begin
                        cmd.run_init = 1'b1;
                        state_next   = ST_SCAN;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read of the round is compared on this edge
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = status.final_round ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_scan_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_issue |-> !cmd.commit && !cmd.run_init && !s_tready)
        else $error("scan issued outside the scan phase");

    a_init_then_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_init |=> cmd.scan_issue)
        else $error("run start not followed by a scan");

    a_commit_then_move: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (cmd.scan_issue || s_tready))
        else $error("commit did not leave the emit phase");

endmodule

FILE: sv/pmd_datapath.sv
// datapath: weight matrix memory, scan counters, min search, tree state and
// output register; depends on pmd_pkg, driven by pmd_ctrl commands
module pmd_datapath
    import pmd_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pmd_cmd_t              cmd,
    output pmd_status_t           status,
    input  logic [VTX_W-1:0]      in_from,
    input  logic [VTX_W-1:0]      in_to,
    input  logic [IN_W_W-1:0]     in_weight,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] n_in,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int NCNT_W = $clog2(MAX_VERTICES+1);
    localparam int ADDR_W = 2 * VIDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int SUM_W  = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;
    localparam logic [6:0] MAXV7 = 7'(MAX_VERTICES);

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    logic [NCNT_W-1:0]       n_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic [NCNT_W-1:0]       edges_reg;
    logic [VIDX_W-1:0]       f_reg, t_reg;
    logic [VIDX_W-1:0]       f_d_reg, t_d_reg;
    logic                    qual_reg;
    logic [WEIGHT_BITS-1:0]  rd_reg;
    logic                    found_reg;
    logic [WEIGHT_BITS-1:0]  best_reg;
    logic [VIDX_W-1:0]       bf_reg, bt_reg;

    logic                    m_tvalid_reg;
    logic [VTX_W-1:0]        o_from_reg, o_to_reg;
    logic [OUT_W_W-1:0]      o_weight_reg;
    logic [TOTAL_W-1:0]      o_total_reg;
    logic                    o_valid_reg, o_disc_reg, o_last_reg;

    logic [6:0]              from7, to7;
    logic                    load_ok;
    logic [ADDR_W-1:0]       waddr;
    logic [31:0]             wt32;
    logic [VIDX_W-1:0]       nm1;
    logic                    single;
    logic [SUM_W-1:0]        sum;
    logic [TOTAL_W-1:0]      total_new;
    logic [31:0]             best32;
    logic [6:0]              bf7, bt7;

    assign from7   = 7'(in_from);
    assign to7     = 7'(in_to);
    assign load_ok = (from7 < MAXV7) && (to7 < MAXV7);
    assign waddr   = {from7[VIDX_W-1:0], to7[VIDX_W-1:0]};
    assign wt32    = 32'(in_weight);

    assign nm1     = VIDX_W'(n_reg - 1'b1);
    assign single  = (n_reg == NCNT_W'(1));

    assign sum       = SUM_W'(total_reg) + SUM_W'(best_reg);
    assign total_new = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign best32    = 32'(best_reg);
    assign bf7       = 7'(bf_reg);
    assign bt7       = 7'(bt_reg);

    assign status.scan_last   = (f_reg == nm1) && (t_reg == nm1);
    assign status.out_free    = !m_tvalid_reg || m_tready;
    assign status.final_round = single || !found_reg ||
        (NCNT_W'(edges_reg + 1'b1) == NCNT_W'(n_reg - 1'b1));

    // matrix store: writes only while idle, reads during scan
    always_ff @(posedge aclk) begin
        if (cmd.load_wr && load_ok) begin
            mem[waddr] <= wt32[WEIGHT_BITS-1:0];
        end
        rd_reg <= mem[{f_reg, t_reg}];
    end

    // scan counters and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg    <= '0;
            t_reg    <= '0;
            qual_reg <= 1'b0;
        end else begin
            qual_reg <= cmd.scan_issue && visited_reg[f_reg] && !visited_reg[t_reg];
            if (cmd.run_init || cmd.commit) begin
                f_reg <= '0;
                t_reg <= '0;
            end else if (cmd.scan_issue) begin
                if (t_reg == nm1) begin
                    t_reg <= '0;
                    f_reg <= f_reg + 1'b1;
                end else begin
                    t_reg <= t_reg + 1'b1;
                end
            end
        end
        f_d_reg <= f_reg;
        t_d_reg <= t_reg;
    end

    // minimum search, later entry wins on a tie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.run_init || cmd.commit) begin
            found_reg <= 1'b0;
        end else if (qual_reg && (rd_reg != '0) && (!found_reg || rd_reg <= best_reg)) begin
            found_reg <= 1'b1;
        end
        if (qual_reg && (rd_reg != '0) && (!found_reg || rd_reg <= best_reg)) begin
            best_reg <= rd_reg;
            bf_reg   <= f_d_reg;
            bt_reg   <= t_d_reg;
        end
    end

    // run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= NCNT_W'(MAX_VERTICES);
            visited_reg <= '0;
            total_reg   <= '0;
            edges_reg   <= '0;
        end else if (cmd.run_init) begin
            n_reg       <= n_in;
            visited_reg <= MAX_VERTICES'(1);
            total_reg   <= '0;
            edges_reg   <= '0;
        end else if (cmd.commit && found_reg) begin
            visited_reg[bt_reg] <= 1'b1;
            total_reg           <= total_new;
            edges_reg           <= edges_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            o_from_reg   <= found_reg ? bf7[VTX_W-1:0] : '0;
            o_to_reg     <= found_reg ? bt7[VTX_W-1:0] : '0;
            o_weight_reg <= found_reg ? best32[OUT_W_W-1:0] : '0;
            o_total_reg  <= found_reg ? total_new : total_reg;
            o_valid_reg  <= found_reg;
            o_disc_reg   <= !found_reg && !single;
            o_last_reg   <= status.final_round;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({o_total_reg, o_weight_reg, o_to_reg, o_from_reg});
    assign m_tuser  = {o_disc_reg, o_valid_reg};
    assign m_tlast  = o_last_reg;

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed over a pending beat");

    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && found_reg) |=> (total_reg >= $past(total_reg)))
        else $error("running total went down");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (best_reg != '0))
        else $error("zero weight taken as an edge");

endmodule

FILE: sv/prim_mst_dense.sv
// prim minimum spanning tree over a dense weight matrix
// s channel: tuser = action (0 load, 1 start); tdata = from, to, weight.
// a load beat writes one weight and causes no result; rows or columns at or
// above MAX_VERTICES are dropped. zero weight means no edge.
// a start beat runs prim from vertex 0 over vertex_count vertices (0 acts
// as 1, above MAX_VERTICES as MAX_VERTICES). each round reads every pair of
// the n x n block from the single-port matrix memory, one entry per cycle,
// then waits until the output register is free to commit its result; a run
// has n-1 rounds. one m beat per round; m_tlast marks the end, early on a
// disconnected graph. a start with one vertex gives one empty beat.
// s_tready is high only between runs; the final beat sits in the output
// register while new loads are taken. a stalled receiver holds the run.
// cfg_wr_en/cfg_wr_data write vertex_count (reset 32); write only between runs (not enforced).
// reset (aresetn low, synchronous) returns to idle and drops a pending beat;
// the matrix is not cleared and entries must be written before a run.
// depends on pmd_pkg, pmd_ctrl and pmd_datapath
module prim_mst_dense
    import pmd_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [VCNT_W-1:0]    cfg_wr_data,   // vertex_count
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // from_vertex[4:0], to_vertex[9:5], weight[25:10]
    input  logic [0:0]           s_tuser,       // action[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // edge_from[4:0], edge_to[9:5],
                                                // edge_weight[25:10], running_total[46:26]
    output logic [1:0]           m_tuser,       // edge_valid[0], disconnected[1]
    output logic                 m_tlast
);

    localparam int NCNT_W = $clog2(MAX_VERTICES+1);
    localparam logic [6:0] MAXV7 = 7'(MAX_VERTICES);

    logic [VCNT_W-1:0] vc_reg;
    logic [6:0]        vc7;
    logic [6:0]        n7;
    logic [NCNT_W-1:0] n_in;
    pmd_cmd_t          cmd;
    pmd_status_t       status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= VCNT_W'(32);
        end else if (cfg_wr_en) begin
            vc_reg <= cfg_wr_data;
        end
    end

    assign vc7  = 7'(vc_reg);
    assign n7   = (vc7 == 7'd0) ? 7'd1 : ((vc7 > MAXV7) ? MAXV7 : vc7);
    assign n_in = NCNT_W'(n7);

    pmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pmd_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_from   (s_tdata[4:0]),
        .in_to     (s_tdata[9:5]),
        .in_weight (s_tdata[25:10]),
        .n_in      (n_in),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: dv/prim_mst_dense_test.sv
// self-checking testbench for prim_mst_dense: loads weight matrices, starts prim runs
// and checks every edge beat against an in-bench predictor of the spanning tree
// depends on pmd_pkg and prim_mst_dense
module prim_mst_dense_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pmd_pkg::*;

    localparam int NV       = 32;
    localparam int RND_BEATS = 410;

    typedef struct {
        logic               action;
        logic [VTX_W-1:0]   src;
        logic [VTX_W-1:0]   dst;
        logic [IN_W_W-1:0]  wt;
    } mst_in_t;

    typedef struct {
        logic [VTX_W-1:0]   src;
        logic [VTX_W-1:0]   dst;
        logic [OUT_W_W-1:0] wt;
        logic [TOTAL_W-1:0] total;
        logic               found;
        logic               disc;
        logic               fin;
    } mst_edge_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [VCNT_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [0:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    prim_mst_dense #(
        .MAX_VERTICES (NV),
        .WEIGHT_BITS  (16)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state, advanced on accepted beats
    logic [IN_W_W-1:0] wt_mem [NV][NV];
    logic [VCNT_W-1:0] vcnt = 6'd32;

    // generator side bookkeeping
    bit gen_seen [NV][NV];

    mst_in_t   in_beats [$];
    mst_edge_t edge_due [$];
    mst_in_t   on_bus;
    mst_edge_t want_edge;
    int        err_cnt = 0;
    int        cyc = 0;
    logic      calm;

    // long quiet window, recurring periodically, where neither side idles
    assign calm = (cyc % 4000) < 900;

    always @(posedge aclk) cyc <= cyc + 1;

    task automatic note_err(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic int eff_n(logic [VCNT_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > NV)
            return NV;
        return int'(v);
    endfunction

    task automatic push_edge(logic [VTX_W-1:0] f, logic [VTX_W-1:0] t, logic [OUT_W_W-1:0] w,
                             logic [TOTAL_W-1:0] tot, logic fnd, logic dc, logic fi);
        mst_edge_t e;
        e.src   = f;
        e.dst   = t;
        e.wt    = w;
        e.total = tot;
        e.found = fnd;
        e.disc  = dc;
        e.fin   = fi;
        edge_due.insert(edge_due.size(), e);
    endtask

    // applies one accepted beat: a load writes the matrix, a start grows the tree
    task automatic prim_predict(mst_in_t b);
        int n;
        logic [NV-1:0] in_tree;
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W:0] sum;
        logic [OUT_W_W-1:0] best;
        logic found;
        int bf;
        int bt;
        if (b.action == ACT_LOAD) begin
            wt_mem[b.src][b.dst] = b.wt;
            return;
        end
        n = eff_n(vcnt);
        if (n == 1) begin
            push_edge('0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
            return;
        end
        in_tree = 1;
        total = '0;
        for (int r = 0; r < n - 1; r++) begin
            found = 1'b0;
            best = '0;
            bf = 0;
            bt = 0;
            for (int f = 0; f < n; f++) begin
                for (int t = 0; t < n; t++) begin
                    // ties go to the entry scanned last
                    if (in_tree[f] && !in_tree[t] && wt_mem[f][t] != 0 &&
                        (!found || wt_mem[f][t] <= best)) begin
                        found = 1'b1;
                        best = wt_mem[f][t];
                        bf = f;
                        bt = t;
                    end
                end
            end
            if (!found) begin
                push_edge('0, '0, '0, total, 1'b0, 1'b1, 1'b1);
                return;
            end
            in_tree[bt] = 1'b1;
            sum = {1'b0, total} + best;
            total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            push_edge(VTX_W'(bf), VTX_W'(bt), best, total, 1'b1, 1'b0, r == n - 2);
        end
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                prim_predict(on_bus);
            if (!s_tvalid || s_tready) begin
                if (in_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
                    on_bus = in_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-26){1'b0}}, on_bus.wt, on_bus.dst, on_bus.src};
                    s_tuser  <= on_bus.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 19);
        if (aresetn && m_tvalid && m_tready) begin
            if (edge_due.size() == 0) begin
                note_err("beat with nothing due", m_tdata[31:0], 0);
            end else begin
                want_edge = edge_due.pop_front();
                if (m_tdata[4:0] != want_edge.src)
                    note_err("edge_from", m_tdata[4:0], want_edge.src);
                if (m_tdata[9:5] != want_edge.dst)
                    note_err("edge_to", m_tdata[9:5], want_edge.dst);
                if (m_tdata[25:10] != want_edge.wt)
                    note_err("edge_weight", m_tdata[25:10], want_edge.wt);
                if (m_tdata[46:26] != want_edge.total)
                    note_err("running_total", m_tdata[46:26], want_edge.total);
                if (m_tuser[0] != want_edge.found)
                    note_err("edge_valid", m_tuser[0], want_edge.found);
                if (m_tuser[1] != want_edge.disc)
                    note_err("disconnected", m_tuser[1], want_edge.disc);
                if (m_tlast != want_edge.fin)
                    note_err("last", m_tlast, want_edge.fin);
            end
        end
    end

    function automatic logic [IN_W_W-1:0] pick_weight(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return (r < 15) ? '0 : IN_W_W'($urandom_range(1, 65535));
            1: return IN_W_W'($urandom_range(0, 3));   // dense ties
            2: return (r < 65) ? '0 : IN_W_W'($urandom_range(1, 65535));
            default: begin
                case (r % 5)
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'hFFFF;
                    3: return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
        endcase
    endfunction

    task automatic push_beat(logic act, int f, int t, logic [IN_W_W-1:0] w);
        mst_in_t b;
        b.action = act;
        b.src    = VTX_W'(f);
        b.dst    = VTX_W'(t);
        b.wt     = w;
        if (act == ACT_LOAD)
            gen_seen[f][t] = 1'b1;
        in_beats.insert(in_beats.size(), b);
    endtask

    // every entry of the active block gets written before the scan can read it
    task automatic push_start();
        int n;
        n = eff_n(vcnt);
        for (int f = 0; f < n; f++)
            for (int t = 0; t < n; t++)
                if (!gen_seen[f][t])
                    push_beat(ACT_LOAD, f, t, pick_weight(0));
        push_beat(ACT_START, 0, 0, '0);
    endtask

    task automatic wait_quiet();
        do
            @(negedge aclk);
        while (in_beats.size() != 0 || s_tvalid || edge_due.size() != 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_vcount(logic [VCNT_W-1:0] v);
        wait_quiet();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vcnt = v;
        @(negedge aclk);
    endtask

    initial begin
        int rnd_items;
        int phase;
        int n;
        int runs;
        int mode;
        int style;
        int r;
        logic [VCNT_W-1:0] v;
        rnd_items = 0;
        phase = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // single vertex, and a count of zero acting as one
        set_vcount(6'd1);
        push_start();
        set_vcount(6'd0);
        push_start();

        // two vertices: heaviest weight, then no edge at all
        set_vcount(6'd2);
        push_beat(ACT_LOAD, 0, 1, 16'hFFFF);
        push_beat(ACT_LOAD, 1, 0, 16'h0001);
        push_start();
        push_beat(ACT_LOAD, 0, 1, 16'h0000);
        push_start();

        // three vertices: equal weights pick the later entry, then a graph cut after one edge
        set_vcount(6'd3);
        push_beat(ACT_LOAD, 0, 1, 16'd4);
        push_beat(ACT_LOAD, 0, 2, 16'd4);
        push_beat(ACT_LOAD, 2, 1, 16'd4);
        push_start();
        push_beat(ACT_LOAD, 0, 1, 16'd0);
        push_beat(ACT_LOAD, 2, 1, 16'd0);
        push_start();
        push_beat(ACT_LOAD, 31, 31, 16'hAAAA);
        push_beat(ACT_LOAD, 31, 0, 16'h5555);

        while (rnd_items < RND_BEATS) begin
            if (phase == 1) begin
                v = 6'd63;
            end else if (phase == 4) begin
                v = 6'd32;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    v = 6'd0;
                else if (r < 10)
                    v = 6'd1;
                else if (r < 25)
                    v = VCNT_W'($urandom_range(9, 16));
                else
                    v = VCNT_W'($urandom_range(2, 8));
            end
            set_vcount(v);
            n = eff_n(v);
            runs = (n > 16) ? 2 : $urandom_range(1, 3);
            for (int k = 0; k < runs; k++) begin
                mode = $urandom_range(0, 3);
                style = $urandom_range(0, 9);
                if (n <= 16 && style < 8) begin
                    for (int f = 0; f < n; f++)
                        for (int t = 0; t < n; t++) begin
                            push_beat(ACT_LOAD, f, t, pick_weight(mode));
                            rnd_items++;
                        end
                end else begin
                    repeat ($urandom_range(1, 3 * n)) begin
                        push_beat(ACT_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  pick_weight(mode));
                        rnd_items++;
                    end
                end
                // stray loads anywhere in the matrix
                if (style >= 8) begin
                    repeat ($urandom_range(1, 6)) begin
                        push_beat(ACT_LOAD, $urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                                  pick_weight(0));
                        rnd_items++;
                    end
                end
                push_start();
                rnd_items++;
            end
            phase++;
        end

        wait_quiet();
        if (edge_due.size() != 0)
            note_err("beats never seen", edge_due.size(), 0);
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pmd_pkg.sv
sv/pmd_ctrl.sv
sv/pmd_datapath.sv
sv/prim_mst_dense.sv
dv/prim_mst_dense_test.sv
